>>> sv/oemd_pkg.sv
// Shared types, constants and tables for the execution-report decoder.
package oemd_pkg;

    localparam int MAX_BF_BYTES = 8;
    localparam int MAX_DIGITS   = 13;
    localparam int RADIX        = 36;

    localparam logic [8:0] POS_MAX      = 9'd511;
    localparam logic [8:0] ORDID_FIRST  = 9'd18;
    localparam logic [8:0] ORDID_LAST   = 9'd37;
    localparam logic [8:0] EXEC_FIRST   = 9'd38;
    localparam logic [8:0] EXEC_LAST    = 9'd45;
    localparam logic [8:0] FILL_FIRST   = 9'd46;
    localparam logic [8:0] FILL_LAST    = 9'd49;
    localparam logic [8:0] PRICE_FIRST  = 9'd50;
    localparam logic [8:0] PRICE_LAST   = 9'd57;
    localparam logic [8:0] ACT_FIRST    = 9'd58;
    localparam logic [8:0] ACT_LAST     = 9'd61;
    localparam logic [8:0] LIQ_POS      = 9'd62;
    localparam logic [8:0] BF_COUNT_POS = 9'd69;
    localparam logic [8:0] BF_START     = 9'd70;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_0 = 8'h30;

    localparam logic [63:0] LIQ_UNKNOWN = 64'd0;
    localparam logic [63:0] LIQ_ADDED   = 64'd1;
    localparam logic [63:0] LIQ_REMOVED = 64'd2;

    localparam logic [3:0] KIND_ORDID  = 4'd0;
    localparam logic [3:0] KIND_EXECID = 4'd1;
    localparam logic [3:0] KIND_LIQ    = 4'd2;
    localparam logic [3:0] KIND_FILLED = 4'd3;
    localparam logic [3:0] KIND_PRICE  = 4'd4;
    localparam logic [3:0] KIND_ACTIVE = 4'd5;
    localparam logic [3:0] KIND_SYMBOL = 4'd6;
    localparam logic [3:0] KIND_END    = 4'd9;

    // reciprocal of 36 scaled by 2^18, exact for dividends below 9216
    localparam logic [12:0] RECIP_36    = 13'd7282;
    localparam int          RECIP_SHIFT = 18;

    localparam logic [7:0] EXEC_MASK [8] =
        '{8'h7F, 8'h7D, 8'hDF, 8'h00, 8'h00, 8'h03, 8'h80, 8'h09};
    localparam logic [7:0] REQ_MASK [8] =
        '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h01};
    // requested fields counted in bitfield bytes before this one
    localparam logic [1:0] REQ_BASE [8] =
        '{2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2};
    localparam logic [3:0] FIELD_LEN [3] = '{4'd8, 4'd4, 4'd2};
    localparam logic [4:0] ELEM_SIZE [8][8] = '{
        '{5'd1,  5'd8, 5'd8, 5'd1, 5'd1,  5'd1, 5'd4, 5'd0},
        '{5'd8,  5'd0, 5'd3, 5'd1, 5'd16, 5'd4, 5'd1, 5'd0},
        '{5'd16, 5'd4, 5'd4, 5'd1, 5'd4,  5'd0, 5'd4, 5'd3},
        '{5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0},
        '{5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0},
        '{5'd8,  5'd1, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0},
        '{5'd0,  5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd4},
        '{5'd2,  5'd0, 5'd0, 5'd4, 5'd0,  5'd0, 5'd0, 5'd0}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [63:0] field_value;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_ONE,
        ST_EOM
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic emit_digit;
        logic emit_one;
        logic emit_eom;
    } cmd_t;

    typedef struct packed {
        logic exec_start;
        logic has_one;
        logic in_eom;
        logic eom_pending;
        logic div_done;
        logic digit_last;
        logic out_free;
    } sts_t;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10)
            c = CHAR_0 + 8'(d);
        else
            c = CHAR_A + 8'(d) - 8'd10;
        return c;
    endfunction

endpackage

>>> sv/oemd_ctrl.sv
// Controller state machine: sequences accept, base-36 division and result emission.
module oemd_ctrl
    import oemd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    output logic byte_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    if (sts.exec_start)
                        state_next = ST_DIV;
                    else if (sts.has_one)
                        state_next = ST_ONE;
                    else if (sts.in_eom)
                        state_next = ST_EOM;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (sts.out_free && sts.digit_last)
                    state_next = sts.eom_pending ? ST_EOM : ST_IDLE;
            end
            ST_ONE:
            begin
                if (sts.out_free)
                    state_next = sts.eom_pending ? ST_EOM : ST_IDLE;
            end
            ST_EOM:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        byte_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                byte_stall = 1'b0;
                cmd.accept = byte_valid;
            end
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_DIGIT: cmd.emit_digit = sts.out_free;
            ST_ONE:   cmd.emit_one   = sts.out_free;
            ST_EOM:   cmd.emit_eom   = sts.out_free;
            default:  byte_stall     = 1'b1;
        endcase
    end

endmodule

>>> sv/oemd_dpath.sv
// Datapath: message field state, divide-by-36 unit, digit buffer and output register.
module oemd_dpath
    import oemd_pkg::*;
#(
    parameter int MAX_BITFIELD_BYTES = MAX_BF_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  byte_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      field_valid,
    input  logic      field_stall,
    output out_item_t field_item
);

    logic [8:0]  pos_reg;
    logic [63:0] acc_reg;
    logic [3:0]  bf_count_reg;
    logic [8:0]  run_reg;
    logic [8:0]  off_reg [3];
    logic [2:0]  pres_reg;
    logic        eom_reg;
    logic [3:0]  pend_kind_reg;
    logic [63:0] pend_value_reg;
    logic [63:0] div_reg;
    logic [5:0]  rem_reg;
    logic [2:0]  div_byte_reg;
    logic [3:0]  dig_cnt_reg;
    logic [5:0]  digit_buf_reg [MAX_DIGITS];
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic [7:0]  b;
    logic [2:0]  acc_k;
    logic        in_acc;
    logic [63:0] acc_next;
    logic        in_bf;
    logic [2:0]  bf_idx;
    logic [8:0]  run_next;
    logic [8:0]  off_next [3];
    logic [2:0]  pres_next;
    logic        opt_hit;
    logic [3:0]  opt_kind;
    logic        has_one;
    logic [3:0]  one_kind;
    logic [63:0] one_value;
    logic [13:0] div_x;
    logic [26:0] div_prod;
    logic [7:0]  div_q;
    logic [13:0] div_r;
    logic [63:0] div_shift;
    logic        digit_end;
    logic        div_done;
    logic        out_free;
    logic [3:0]  dig_idx;

    assign b = byte_item.data_byte;

    // little-endian accumulation over the numeric fields
    always_comb
    begin
        in_acc = (pos_reg >= EXEC_FIRST) && (pos_reg <= ACT_LAST);
        if (pos_reg <= EXEC_LAST)
            acc_k = 3'(pos_reg - EXEC_FIRST);
        else if (pos_reg <= FILL_LAST)
            acc_k = 3'(pos_reg - FILL_FIRST);
        else if (pos_reg <= PRICE_LAST)
            acc_k = 3'(pos_reg - PRICE_FIRST);
        else
            acc_k = 3'(pos_reg - ACT_FIRST);
        acc_next = ((acc_k == 3'd0) ? 64'd0 : acc_reg) | (64'(b) << {acc_k, 3'b000});
    end

    // bitfield byte: locate requested fields and grow the optional area
    always_comb
    begin
        logic [1:0] k;
        logic [8:0] run;
        in_bf  = (pos_reg >= BF_START) &&
                 ({1'b0, pos_reg} < (10'(BF_START) + 10'(bf_count_reg)));
        bf_idx = 3'(pos_reg - BF_START);
        k      = REQ_BASE[bf_idx];
        run    = run_reg;
        pres_next = pres_reg;
        for (int i = 0; i < 3; i++)
            off_next[i] = off_reg[i];
        for (int j = 0; j < 8; j++)
        begin
            if (REQ_MASK[bf_idx][j])
            begin
                if (b[j] && (k < 2'd3))
                begin
                    off_next[k]  = BF_START + 9'(bf_count_reg) + run;
                    pres_next[k] = 1'b1;
                end
                k = k + 2'd1;
            end
            if (EXEC_MASK[bf_idx][j] && b[j])
                run = run + 9'(ELEM_SIZE[bf_idx][j]);
        end
        run_next = run;
    end

    // optional field bytes; the located ranges never overlap
    always_comb
    begin
        opt_hit  = 1'b0;
        opt_kind = KIND_SYMBOL;
        if ((pos_reg >= BF_START) && (pos_reg != POS_MAX) && !in_bf && (b != 8'd0))
        begin
            for (int i = 2; i >= 0; i--)
            begin
                if (pres_reg[i] && (pos_reg >= off_reg[i]) &&
                    ({1'b0, pos_reg} < (10'(off_reg[i]) + 10'(FIELD_LEN[i]))))
                begin
                    opt_hit  = 1'b1;
                    opt_kind = KIND_SYMBOL + 4'(i);
                end
            end
        end
    end

    always_comb
    begin
        has_one   = 1'b0;
        one_kind  = KIND_ORDID;
        one_value = 64'(b);
        if ((pos_reg >= ORDID_FIRST) && (pos_reg <= ORDID_LAST))
        begin
            has_one = (b != 8'd0);
        end
        else if (pos_reg == FILL_LAST)
        begin
            has_one   = 1'b1;
            one_kind  = KIND_FILLED;
            one_value = acc_next;
        end
        else if (pos_reg == PRICE_LAST)
        begin
            has_one   = 1'b1;
            one_kind  = KIND_PRICE;
            one_value = acc_next;
        end
        else if (pos_reg == ACT_LAST)
        begin
            has_one   = 1'b1;
            one_kind  = KIND_ACTIVE;
            one_value = acc_next;
        end
        else if (pos_reg == LIQ_POS)
        begin
            has_one  = 1'b1;
            one_kind = KIND_LIQ;
            if (b == CHAR_A)
                one_value = LIQ_ADDED;
            else if (b == CHAR_R)
                one_value = LIQ_REMOVED;
            else
                one_value = LIQ_UNKNOWN;
        end
        else if (opt_hit)
        begin
            has_one  = 1'b1;
            one_kind = opt_kind;
        end
    end

    // one quotient byte per cycle, most significant byte first
    always_comb
    begin
        div_x     = {rem_reg, div_reg[63:56]};
        div_prod  = 27'(div_x) * 27'(RECIP_36);
        div_q     = div_prod[RECIP_SHIFT +: 8];
        div_r     = div_x - 14'(div_q) * 14'(RADIX);
        div_shift = {div_reg[55:0], div_q};
        digit_end = (div_byte_reg == 3'd7);
        div_done  = digit_end &&
                    ((div_shift == 64'd0) || (dig_cnt_reg == 4'(MAX_DIGITS - 1)));
    end

    assign out_free = !out_valid_reg || !field_stall;
    assign dig_idx  = dig_cnt_reg - 4'd1;

    always_comb
    begin
        sts.exec_start  = (pos_reg == EXEC_LAST) && (acc_next != 64'd0);
        sts.has_one     = has_one;
        sts.in_eom      = byte_item.end_of_message;
        sts.eom_pending = eom_reg;
        sts.div_done    = div_done;
        sts.digit_last  = (dig_cnt_reg == 4'd1);
        sts.out_free    = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            acc_reg      <= '0;
            bf_count_reg <= '0;
            run_reg      <= '0;
            pres_reg     <= '0;
            eom_reg      <= 1'b0;
            rem_reg      <= '0;
            div_byte_reg <= '0;
            dig_cnt_reg  <= '0;
            for (int i = 0; i < 3; i++)
                off_reg[i] <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                eom_reg <= byte_item.end_of_message;
                if (byte_item.end_of_message)
                begin
                    pos_reg      <= '0;
                    acc_reg      <= '0;
                    bf_count_reg <= '0;
                    run_reg      <= '0;
                    pres_reg     <= '0;
                    for (int i = 0; i < 3; i++)
                        off_reg[i] <= '0;
                end
                else
                begin
                    if (pos_reg != POS_MAX)
                        pos_reg <= pos_reg + 9'd1;
                    if (in_acc)
                        acc_reg <= acc_next;
                    if (pos_reg == BF_COUNT_POS)
                    begin
                        if (b > 8'(MAX_BITFIELD_BYTES))
                            bf_count_reg <= 4'(MAX_BITFIELD_BYTES);
                        else
                            bf_count_reg <= b[3:0];
                    end
                    if (in_bf)
                    begin
                        run_reg  <= run_next;
                        pres_reg <= pres_next;
                        for (int i = 0; i < 3; i++)
                            off_reg[i] <= off_next[i];
                    end
                end
                rem_reg      <= '0;
                div_byte_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_byte_reg <= div_byte_reg + 3'd1;
                if (digit_end)
                begin
                    rem_reg     <= '0;
                    dig_cnt_reg <= dig_cnt_reg + 4'd1;
                    // a full set of digits leaves no room for the end result
                    if (div_done && (dig_cnt_reg == 4'(MAX_DIGITS - 1)))
                        eom_reg <= 1'b0;
                end
                else
                begin
                    rem_reg <= div_r[5:0];
                end
            end
            else if (cmd.emit_digit)
            begin
                dig_cnt_reg <= dig_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_kind_reg  <= one_kind;
            pend_value_reg <= one_value;
            div_reg        <= acc_next;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_shift;
            if (digit_end)
                digit_buf_reg[dig_cnt_reg] <= div_r[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_digit || cmd.emit_one || cmd.emit_eom)
            out_valid_reg <= 1'b1;
        else if (!field_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_digit)
        begin
            out_item_reg.field_kind  <= KIND_EXECID;
            out_item_reg.field_value <= 64'(digit_char(digit_buf_reg[dig_idx]));
            out_item_reg.last_of_run <= (dig_cnt_reg == 4'd1) && !eom_reg;
        end
        else if (cmd.emit_one)
        begin
            out_item_reg.field_kind  <= pend_kind_reg;
            out_item_reg.field_value <= pend_value_reg;
            out_item_reg.last_of_run <= !eom_reg;
        end
        else if (cmd.emit_eom)
        begin
            out_item_reg.field_kind  <= KIND_END;
            out_item_reg.field_value <= 64'd0;
            out_item_reg.last_of_run <= 1'b1;
        end
    end

    assign field_valid = out_valid_reg;
    assign field_item  = out_item_reg;

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        dig_cnt_reg <= 4'(MAX_DIGITS))
        else $error("digit count beyond buffer depth");

    a_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < 6'(RADIX))
        else $error("division remainder out of range");

    a_bf_count: assert property (@(posedge clk) disable iff (!rst_n)
        bf_count_reg <= 4'(MAX_BITFIELD_BYTES))
        else $error("bitfield count not saturated");

endmodule

>>> sv/order_execution_message_decoder.sv
// Top level of the execution-report decoder: controller and datapath.
//
// Input channel byte_*: one message byte per transaction, from offset zero;
// end_of_message marks the last byte and clears all message state after it.
// Output channel field_*: decoded fields, one per transaction, last_of_run set
// on the final field caused by one input byte.
// Bytes that produce nothing are taken directly in ST_IDLE. A byte that
// produces one field emits it in ST_ONE, followed by ST_EOM if it also
// ends the message. The last byte of a nonzero execution id runs the
// divide-by-36 unit, which forms one quotient byte per cycle for up to 13
// base-36 digits; the digits are then emitted most significant first.
// The output register holds a finished field while the next input byte is
// taken; when the receiver stalls, emission waits and byte_stall stays high
// until the pending fields of the current byte are out.
// Reset clears position, field offsets, counters and the output valid; the
// block is ready for offset zero right after reset.
module order_execution_message_decoder
    import oemd_pkg::*;
#(
    parameter int MAX_BITFIELD_BYTES = MAX_BF_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      field_valid,
    input  logic      field_stall,
    output out_item_t field_item
);

    cmd_t cmd;
    sts_t sts;

    oemd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    oemd_dpath #(
        .MAX_BITFIELD_BYTES (MAX_BITFIELD_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_item   (byte_item),
        .cmd         (cmd),
        .sts         (sts),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_item  (field_item)
    );

endmodule
